// ===== rtl/core/lru_pkg.sv =====
package lru_pkg;

	localparam int unsigned ACC_W   = 48;
	localparam int unsigned DATA_W  = 32;
	localparam int unsigned OUT_CNT = 16;
	localparam logic [33:0] LN2_Q32 = 34'd2977044472;

	typedef enum logic [1:0] {
		KIND_BCE = 2'd0,
		KIND_MSE = 2'd1,
		KIND_CCE = 2'd2,
		KIND_NOP = 2'd3
	} kind_t;

	// one classified element handed from front to back
	typedef struct packed {
		logic signed [DATA_W-1:0] pred;
		logic signed [DATA_W-1:0] targ;
		logic                     last;
		kind_t                    kind;
	} elem_t;

	// log2(1 + i/2^tb) in Q32 by repeated squaring on a Q31 mantissa
	function automatic logic [32:0] log2_mant(input logic [63:0] y0);
		logic [63:0]  y;
		logic [127:0] sq;
		logic [32:0]  r;
		y = y0;
		r = '0;
		for (int b = 31; b >= 0; b--) begin
			sq = y * y;
			y  = sq[94:31];
			if (y >= 64'h1_0000_0000) begin
				y    = y >> 1;
				r[b] = 1'b1;
			end
		end
		return r;
	endfunction

	function automatic logic [32:0] log_entry(input int unsigned i, input int unsigned tb);
		if (i >= (32'd1 << tb))
			return 33'h1_0000_0000;
		return log2_mant((64'd1 << 31) + (64'(i) << (31 - tb)));
	endfunction

endpackage

// ===== rtl/core/lru_front.sv =====
// Input side: takes items, samples the loss kind, pushes into a 2-entry queue.
module lru_front (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 s_axis_tvalid,
	output logic                 s_axis_tready,
	input  logic [63:0]          s_axis_tdata,
	input  logic                 s_axis_tlast,
	input  logic [1:0]           kind,
	output logic                 q_valid,
	input  logic                 q_pop,
	output lru_pkg::elem_t       q_head
);
	lru_pkg::elem_t mem_q [2];
	logic           wp_q, rp_q;
	logic [1:0]     cnt_q;
	logic           push;

	assign s_axis_tready = (cnt_q != 2'd2);
	assign push          = s_axis_tvalid && s_axis_tready;
	assign q_valid       = (cnt_q != 2'd0);
	assign q_head        = mem_q[rp_q];

	always_ff @(posedge clk) begin
		if (push) begin
			mem_q[wp_q].pred <= s_axis_tdata[31:0];
			mem_q[wp_q].targ <= s_axis_tdata[63:32];
			mem_q[wp_q].last <= s_axis_tlast;
			mem_q[wp_q].kind <= lru_pkg::kind_t'(kind);
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wp_q  <= 1'b0;
			rp_q  <= 1'b0;
			cnt_q <= 2'd0;
		end else begin
			if (push)
				wp_q <= ~wp_q;
			if (q_pop)
				rp_q <= ~rp_q;
			cnt_q <= cnt_q + 2'(push) - 2'(q_pop);
		end
	end
endmodule

// ===== rtl/core/lru_log.sv =====
// Natural log pipeline: normalize/lookup, interpolate, scale by ln2.
module lru_log #(
	parameter int unsigned FRAC_BITS      = 16,
	parameter int unsigned LOG_TABLE_BITS = 8
) (
	input  logic               clk,
	input  logic               en,
	input  logic [30:0]        x,
	output logic signed [39:0] ln
);
	localparam int unsigned RB = 31 - LOG_TABLE_BITS;
	localparam int unsigned TS = (1 << LOG_TABLE_BITS) + 1;

	logic [32:0] tbl [TS];
	always_comb
		for (int i = 0; i < TS; i++)
			tbl[i] = lru_pkg::log_entry(i, LOG_TABLE_BITS);

	logic [30:0]             ux;
	logic [4:0]              m;
	logic [61:0]             nsh;
	logic [30:0]             f;
	logic [LOG_TABLE_BITS:0] ia, ib;
	always_comb begin
		ux = (x == '0) ? 31'd1 : x;
		m  = '0;
		for (int b = 0; b < 31; b++)
			if (ux[b])
				m = 5'(b);
		// leading one lands on bit 31, f keeps the 31 bits below it
		nsh = {31'd0, ux} << (5'd31 - m);
		f   = nsh[30:0];
		ia  = {1'b0, f[30:RB]};
		ib  = ia + 1'b1;
	end

	logic [32:0]   lo_s1, hi_s1;
	logic [RB-1:0] rem_s1;
	logic [4:0]    m_s1;
	always_ff @(posedge clk)
		if (en) begin
			lo_s1  <= tbl[ia];
			hi_s1  <= tbl[ib];
			rem_s1 <= f[RB-1:0];
			m_s1   <= m;
		end

	logic signed [33:0] dif;
	logic signed [34+RB:0] prod;
	logic signed [34:0] fp;
	logic signed [6:0]  ip;
	always_comb begin
		dif  = $signed({1'b0, hi_s1}) - $signed({1'b0, lo_s1});
		prod = dif * $signed({1'b0, rem_s1});
		fp   = $signed({2'b0, lo_s1}) + 35'(prod >>> RB);
		ip   = $signed({2'b0, m_s1}) - 7'(FRAC_BITS);
		if (fp < 0) begin
			fp = fp + 35'sh1_0000_0000;
			ip = ip - 7'sd1;
		end
	end

	logic [31:0]       fp_s2;
	logic signed [6:0] ip_s2;
	always_ff @(posedge clk)
		if (en) begin
			fp_s2 <= fp[31:0];
			ip_s2 <= ip;
		end

	logic [65:0]        fm;
	logic signed [72:0] lnq;
	always_comb begin
		fm  = fp_s2 * lru_pkg::LN2_Q32;
		lnq = 73'(ip_s2) * 73'($signed({1'b0, lru_pkg::LN2_Q32}))
			+ $signed(73'(fm[65:32])) + (73'sd1 <<< (31 - FRAC_BITS));
	end

	always_ff @(posedge clk)
		if (en)
			ln <= 40'(lnq >>> (32 - FRAC_BITS));
endmodule

// ===== rtl/core/lru_back.sv =====
// Execution side: per-element term, accumulate, final MSE divide (serial).
module lru_back #(
	parameter int unsigned FRAC_BITS      = 16,
	parameter int unsigned LOG_TABLE_BITS = 8,
	parameter int unsigned COUNT_BITS     = 16
) (
	input  logic           clk,
	input  logic           arst_n,
	input  logic           q_valid,
	output logic           q_pop,
	input  lru_pkg::elem_t q_head,
	output logic           m_axis_tvalid,
	input  logic           m_axis_tready,
	output logic [71:0]    m_axis_tdata
);
	localparam int unsigned W  = lru_pkg::ACC_W;
	localparam int unsigned PL = 4;

	typedef enum logic [3:0] {
		ST_IDLE = 4'b0001,
		ST_LOG  = 4'b0010,
		ST_DIV  = 4'b0100,
		ST_OUT  = 4'b1000
	} st_t;

	st_t state_q;
	logic [2:0] cyc_q;
	lru_pkg::elem_t e_q;
	logic signed [W-1:0] sum_q;
	logic [COUNT_BITS-1:0] cnt_q;
	logic ovf_q;
	logic [W-1:0] mag_q, rem_q;
	logic [5:0] bit_q;
	logic neg_q;
	logic [W-1:0] res_q;
	logic [COUNT_BITS-1:0] res_cnt_q;
	logic res_ovf_q;

	localparam logic signed [33:0] ONE = 34'sd1 <<< FRAC_BITS;
	logic signed [33:0] p, t, pc, pa, pb;
	always_comb begin
		p = 34'(e_q.pred);
		t = 34'(e_q.targ);
		if (e_q.kind == lru_pkg::KIND_BCE)
			pc = (p < 1) ? 34'sd1 : ((p > ONE - 1) ? ONE - 1 : p);
		else
			pc = (p < 1) ? 34'sd1 : p;
		pa = pc;
		pb = ONE - pc;
	end

	logic signed [39:0] ln_a, ln_b;
	logic log_en;
	assign log_en = 1'b1;
	lru_log #(.FRAC_BITS(FRAC_BITS), .LOG_TABLE_BITS(LOG_TABLE_BITS)) u_la (
		.clk(clk), .en(log_en), .x(pa[30:0]), .ln(ln_a));
	lru_log #(.FRAC_BITS(FRAC_BITS), .LOG_TABLE_BITS(LOG_TABLE_BITS)) u_lb (
		.clk(clk), .en(log_en), .x(pb[30:0]), .ln(ln_b));

	logic signed [74:0] ta, tb_, s, rs;
	logic signed [32:0] d;
	logic [63:0] sq;
	logic signed [W+1:0] delta, v;
	always_comb begin
		ta = 75'(t) * 75'(ln_a);
		tb_ = 75'(ONE - t) * 75'(ln_b);
		d  = 33'(e_q.pred) - 33'(e_q.targ);
		sq = 64'(d < 0 ? -d : d) * 64'(d < 0 ? -d : d);
		case (e_q.kind)
			lru_pkg::KIND_BCE: s = ta + tb_;
			lru_pkg::KIND_CCE: s = ta;
			default:           s = '0;
		endcase
		rs = (s + (75'sd1 <<< (FRAC_BITS - 1))) >>> FRAC_BITS;
		case (e_q.kind)
			lru_pkg::KIND_MSE:
				delta = $signed({2'b0, 48'((sq + (64'd1 << (FRAC_BITS - 1))) >> FRAC_BITS)});
			lru_pkg::KIND_NOP: delta = '0;
			default:           delta = -(W+2)'(rs);
		endcase
		v = (W+2)'(sum_q) + delta;
	end

	localparam logic signed [W+1:0] AMAX = (W+2)'((50'sd1 <<< (W - 1)) - 1);
	localparam logic signed [W+1:0] AMIN = -(50'sd1 <<< (W - 1));

	logic [W:0] trial;
	assign trial = {rem_q, mag_q[W-1]} - (W+1)'(cnt_q);

	assign q_pop         = (state_q == ST_IDLE) && q_valid;
	assign m_axis_tvalid = (state_q == ST_OUT);
	assign m_axis_tdata  = {7'd0, res_ovf_q, 16'(res_cnt_q), res_q};

	always_ff @(posedge clk)
		if (q_pop)
			e_q <= q_head;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			cyc_q   <= '0;
			sum_q   <= '0;
			cnt_q   <= '0;
			ovf_q   <= 1'b0;
		end else begin
			case (state_q)
				ST_IDLE:
					if (q_valid) begin
						state_q <= ST_LOG;
						cyc_q   <= '0;
					end
				ST_LOG:
					if (cyc_q == 3'(PL - 1)) begin
						logic signed [W+1:0] vs;
						logic [COUNT_BITS-1:0] nc;
						logic no;
						logic signed [W-1:0] fs;
						vs = v;
						no = ovf_q;
						if (v > AMAX) begin vs = AMAX; no = 1'b1; end
						else if (v < AMIN) begin vs = AMIN; no = 1'b1; end
						nc = cnt_q;
						if (&cnt_q) no = 1'b1;
						else nc = cnt_q + 1'b1;
						fs = W'(vs);
						if (!e_q.last) begin
							sum_q   <= fs;
							cnt_q   <= nc;
							ovf_q   <= no;
							state_q <= ST_IDLE;
						end else begin
							res_cnt_q <= nc;
							res_ovf_q <= no;
							sum_q     <= '0;
							ovf_q     <= 1'b0;
							if (e_q.kind == lru_pkg::KIND_MSE) begin
								neg_q <= fs[W-1];
								mag_q <= fs[W-1] ? W'(-fs) : W'(fs);
								rem_q <= W'(nc >> 1);
								cnt_q <= nc;
								bit_q <= '0;
								state_q <= ST_DIV;
							end else begin
								res_q   <= fs;
								cnt_q   <= '0;
								state_q <= ST_OUT;
							end
						end
					end else
						cyc_q <= cyc_q + 3'd1;
				ST_DIV: begin
					// restoring divide of (mag + n/2) by n, one bit per cycle;
					// rem_q preloaded with n/2 works as rounding bias pre-shift
					if (bit_q == 6'd0) begin
						mag_q <= mag_q + rem_q;
						rem_q <= '0;
						bit_q <= 6'd1;
					end else begin
						if (!trial[W]) begin
							rem_q <= trial[W-1:0];
							mag_q <= {mag_q[W-2:0], 1'b1};
						end else begin
							rem_q <= {rem_q[W-2:0], mag_q[W-1]};
							mag_q <= {mag_q[W-2:0], 1'b0};
						end
						if (bit_q == 6'(W)) begin
							state_q <= ST_OUT;
							cnt_q   <= '0;
						end
						bit_q <= bit_q + 6'd1;
					end
				end
				ST_OUT:
					if (m_axis_tready)
						state_q <= ST_IDLE;
				default: state_q <= ST_IDLE;
			endcase
			if (state_q == ST_DIV && bit_q == 6'(W)) begin
				res_q <= neg_q ? W'(-(!trial[W] ? {mag_q[W-2:0], 1'b1}
					: {mag_q[W-2:0], 1'b0}))
					: (!trial[W] ? {mag_q[W-2:0], 1'b1} : {mag_q[W-2:0], 1'b0});
			end
		end
	end
endmodule

// ===== rtl/core/loss_reduction_unit_core.sv =====
// After an item is accepted its term is applied to the sum; on the last item of a vector the
// result is valid at that same edge, or after the serial MSE divide.
// The back end takes a new item only once the term of the last one, from the 3-stage log pipeline, is applied.
// Front queue holds 2 items so input stays open while a result waits, until the queue is full.
// Reset (arst_n low) clears the sum, count, flag, queue and loss_kind to 0.
module loss_reduction_unit_core #(
	parameter int unsigned FRAC_BITS      = 16,
	parameter int unsigned LOG_TABLE_BITS = 8,
	parameter int unsigned COUNT_BITS     = 16
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        s_axis_tvalid,
	output logic        s_axis_tready,
	input  logic [63:0] s_axis_tdata,  // predicted_value[31:0], expected_value[63:32]
	input  logic        s_axis_tlast,  // last_element
	output logic        m_axis_tvalid,
	input  logic        m_axis_tready,
	output logic [71:0] m_axis_tdata,  // loss_value[47:0], element_count[63:48], saturated[64]
	input  logic        cfg_valid,
	output logic        cfg_ready,
	input  logic [1:0]  cfg_data       // loss_kind
);
	logic [1:0]     kind_q;
	logic           q_valid, q_pop;
	lru_pkg::elem_t q_head;

	assign cfg_ready = 1'b1;
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			kind_q <= 2'd0;
		else if (cfg_valid)
			kind_q <= cfg_data;
	end

	lru_front u_front (
		.clk(clk), .arst_n(arst_n),
		.s_axis_tvalid(s_axis_tvalid), .s_axis_tready(s_axis_tready),
		.s_axis_tdata(s_axis_tdata), .s_axis_tlast(s_axis_tlast),
		.kind(kind_q), .q_valid(q_valid), .q_pop(q_pop), .q_head(q_head));

	lru_back #(.FRAC_BITS(FRAC_BITS), .LOG_TABLE_BITS(LOG_TABLE_BITS),
		.COUNT_BITS(COUNT_BITS)) u_back (
		.clk(clk), .arst_n(arst_n),
		.q_valid(q_valid), .q_pop(q_pop), .q_head(q_head),
		.m_axis_tvalid(m_axis_tvalid), .m_axis_tready(m_axis_tready),
		.m_axis_tdata(m_axis_tdata));
endmodule
